### design/wstd_pkg.sv
// ----------------------------------------------------------------------------
// wstd_pkg: shared types and constants of the work-stealing task deque
// Ring depth, field widths, operation kinds and status codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wstd_pkg;

	localparam int QueueDepth = 1024;
	localparam int IdxW       = $clog2(QueueDepth);
	localparam int CntW       = 11;
	localparam int CostW      = 24;
	localparam int IdW        = 8;

	localparam logic [CntW-1:0] ThresholdReset = CntW'(10);

	typedef enum logic [1:0] {
		KIND_TAKE  = 2'd0,
		KIND_STEAL = 2'd1,
		KIND_PUSH  = 2'd2,
		KIND_CLEAR = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_REFUSED = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

endpackage

`default_nettype wire

### design/work_stealing_task_deque_unit.sv
// ----------------------------------------------------------------------------
// work_stealing_task_deque_unit: ring-buffer task deque with head take,
// thresholded tail steal, tail push and clear.
// Every transaction gives its result on done in the cycle after it is
// accepted, through the task store's registered read port.
// Throughput: one transaction per cycle; busy stays low, and the receiver
// cannot stall results. Reset: pointers, count and threshold reset at once;
// the task store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module work_stealing_task_deque_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// command channel
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic [1:0]                 kind,
	input  wire logic [wstd_pkg::CostW-1:0] task_cost,
	input  wire logic [wstd_pkg::IdW-1:0]   requester,
	// configuration: steal threshold
	input  wire logic                       cfg_we,
	input  wire logic [wstd_pkg::CntW-1:0]  cfg_wdata,
	// result channel
	output logic                            done,
	output logic [wstd_pkg::CostW-1:0]      result_cost,
	output logic                            task_valid,
	output logic [1:0]                      status,
	output logic [wstd_pkg::IdW-1:0]        destination,
	output logic [wstd_pkg::CntW-1:0]       task_count
);
	import wstd_pkg::*;

	localparam logic [IdxW-1:0] IdxLast = IdxW'(QueueDepth - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(QueueDepth);

	// Task store: one synchronous write port, one registered read port.
	logic [CostW-1:0] task_store [QueueDepth];

	// Architectural state.
	logic [IdxW-1:0] head_q, tail_q;
	logic [CntW-1:0] total_q;
	logic [CntW-1:0] threshold_q;

	// Next-state and per-transaction decode.
	kind_t           op;
	logic [IdxW-1:0] head_d, tail_d, tail_inc, rd_addr;
	logic [CntW-1:0] total_d;
	logic            hand_out, wr_en;
	status_t         status_d;
	logic [IdW-1:0]  dest_d;

	// Result stage.
	logic             done_s1;
	logic             hand_s1;
	status_t          status_s1;
	logic [IdW-1:0]   dest_s1;
	logic [CntW-1:0]  count_s1;
	logic [CostW-1:0] rd_data_s1;

	// Pointers and count commit at the accept edge, so the next transaction
	// always sees them; a push writes at an edge strictly before any read of
	// the same entry, so the store needs no forwarding path.
	assign busy = 1'b0;
	assign op   = kind_t'(kind);

	always_comb begin
		tail_inc = (tail_q == IdxLast) ? '0 : tail_q + 1'b1;
		head_d   = head_q;
		tail_d   = tail_q;
		total_d  = total_q;
		hand_out = 1'b0;
		wr_en    = 1'b0;
		status_d = ST_OK;
		dest_d   = '0;
		rd_addr  = head_q;
		unique case (op)
			KIND_TAKE: begin
				if (total_q == '0) begin
					status_d = ST_EMPTY;
				end else begin
					hand_out = 1'b1;
					total_d  = total_q - 1'b1;
					head_d   = (head_q == IdxLast) ? '0 : head_q + 1'b1;
				end
			end
			KIND_STEAL: begin
				dest_d  = requester;
				rd_addr = tail_q;
				if (total_q > threshold_q) begin
					hand_out = 1'b1;
					total_d  = total_q - 1'b1;
					tail_d   = (tail_q == '0) ? IdxLast : tail_q - 1'b1;
				end else begin
					status_d = ST_REFUSED;
				end
			end
			KIND_PUSH: begin
				// drop the task when the ring is full
				if (total_q == CntFull) begin
					status_d = ST_FULL;
				end else begin
					wr_en   = 1'b1;
					tail_d  = tail_inc;
					total_d = total_q + 1'b1;
				end
			end
			KIND_CLEAR: begin
				// reset pointers and count only; stored costs stay
				head_d  = '0;
				tail_d  = IdxLast;
				total_d = '0;
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	// Store write and registered read.
	always_ff @(posedge clk) begin
		if (start && wr_en) begin
			task_store[tail_inc] <= task_cost;
		end
		if (start) begin
			rd_data_s1 <= task_store[rd_addr];
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= IdxLast;
			total_q     <= '0;
			threshold_q <= ThresholdReset;
			done_s1     <= 1'b0;
		end else begin
			done_s1 <= start;
			if (cfg_we) begin
				threshold_q <= cfg_wdata;
			end
			if (start) begin
				head_q  <= head_d;
				tail_q  <= tail_d;
				total_q <= total_d;
			end
		end
	end

	// Result payload: hold until the next accepted transaction.
	always_ff @(posedge clk) begin
		if (start) begin
			hand_s1   <= hand_out;
			status_s1 <= status_d;
			dest_s1   <= dest_d;
			count_s1  <= total_d;
		end
	end

	assign done        = done_s1;
	assign task_valid  = hand_s1;
	assign result_cost = hand_s1 ? rd_data_s1 : '0;
	assign status      = status_s1;
	assign destination = dest_s1;
	assign task_count  = count_s1;

endmodule

`default_nettype wire

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for work_stealing_task_deque_unit
// Mirrors the deque in a scoreboard class, drives take, steal, push and clear
// commands with random idle gaps, and checks every done strobe in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import wstd_pkg::*;

	// Cycles without any transaction before the run is declared hung. The
	// longest sender gap is capped at MaxGap and every result comes in the
	// cycle after its command, so this leaves a wide margin.
	localparam int WatchdogLimit = 1000;
	localparam int MaxGap        = 30;

	// One expected answer of the deque, as it must appear on the result ports.
	typedef struct packed {
		logic [CostW-1:0] cost;
		logic             valid;
		status_t          status;
		logic [IdW-1:0]   dest;
		logic [CntW-1:0]  count;
	} deque_answer_t;

	// Scoreboard: keeps its own copy of the ring, the pointers, the count and
	// the steal threshold, and queues one answer per accepted command.
	class deque_ledger;
		logic [CostW-1:0] cost_ring [QueueDepth];
		logic [IdxW-1:0]  head_at;
		logic [IdxW-1:0]  tail_at;
		logic [CntW-1:0]  held;
		logic [CntW-1:0]  threshold;
		deque_answer_t    answers_due [$];
		int mismatches;
		int n_pushed, n_dropped, n_taken, n_empty, n_stolen, n_refused, n_cleared;

		function new();
			head_at   = '0;
			tail_at   = '1;
			held      = '0;
			threshold = ThresholdReset;
			mismatches = 0;
			n_pushed = 0; n_dropped = 0; n_taken = 0; n_empty = 0;
			n_stolen = 0; n_refused = 0; n_cleared = 0;
		endfunction

		// Advance the mirror by one accepted command and queue its answer.
		function void log_command(kind_t k, logic [CostW-1:0] c, logic [IdW-1:0] who);
			deque_answer_t a;
			a = '0;
			a.status = ST_OK;
			case (k)
				KIND_TAKE: begin
					if (held == 0) begin
						a.status = ST_EMPTY;
						n_empty++;
					end else begin
						a.cost  = cost_ring[head_at];
						a.valid = 1'b1;
						held--;
						head_at++;
						n_taken++;
					end
				end
				KIND_STEAL: begin
					a.dest = who;
					if (held > threshold) begin
						a.cost  = cost_ring[tail_at];
						a.valid = 1'b1;
						held--;
						tail_at--;
						n_stolen++;
					end else begin
						a.status = ST_REFUSED;
						n_refused++;
					end
				end
				KIND_PUSH: begin
					if (held >= QueueDepth) begin
						a.status = ST_FULL;
						n_dropped++;
					end else begin
						tail_at++;
						cost_ring[tail_at] = c;
						held++;
						n_pushed++;
					end
				end
				default: begin
					// pointers and count go back to reset, stored costs stay
					head_at = '0;
					tail_at = '1;
					held    = '0;
					n_cleared++;
				end
			endcase
			a.count = held;
			answers_due.push_back(a);
		endfunction

		function void check_field(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
				mismatches++;
			end
		endfunction

		// Compare one done strobe against the oldest queued answer.
		function void match_answer(logic [CostW-1:0] cost, logic valid, logic [1:0] st,
			logic [IdW-1:0] dest, logic [CntW-1:0] count);
			deque_answer_t want;
			if (answers_due.size() == 0) begin
				$display("%0t: result with nothing expected: expected none, actual cost=%0h st=%0d",
					$time, cost, st);
				mismatches++;
				return;
			end
			want = answers_due.pop_front();
			check_field("result_cost", 32'(want.cost), 32'(cost));
			check_field("task_valid", 32'(want.valid), 32'(valid));
			check_field("status", 32'(want.status), 32'(st));
			check_field("destination", 32'(want.dest), 32'(dest));
			check_field("task_count", 32'(want.count), 32'(count));
		endfunction
	endclass

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                start     = 1'b0;
	logic [1:0]          kind      = 2'd0;
	logic [CostW-1:0]    task_cost = '0;
	logic [IdW-1:0]      requester = '0;
	logic                cfg_we    = 1'b0;
	logic [CntW-1:0]     cfg_wdata = '0;
	logic                busy;
	logic                done;
	logic [CostW-1:0]    result_cost;
	logic                task_valid;
	logic [1:0]          status;
	logic [IdW-1:0]      destination;
	logic [CntW-1:0]     task_count;

	deque_ledger sb;
	int quiet_cycles = 0;

	always #1 clk = ~clk;

	work_stealing_task_deque_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.kind        (kind),
		.task_cost   (task_cost),
		.requester   (requester),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.done        (done),
		.result_cost (result_cost),
		.task_valid  (task_valid),
		.status      (status),
		.destination (destination),
		.task_count  (task_count)
	);

	// Result monitor and watchdog. Sampling happens on the rising edge, so the
	// values seen are the ones held during the cycle that the edge ends.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.match_answer(result_cost, task_valid, status, destination, task_count);
			if ((start && !busy) || done || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WatchdogLimit) begin
				$display("%0t: watchdog: no transaction for %0d cycles", $time, quiet_cycles);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// Random cost: the two extremes a quarter of the time, otherwise any value.
	function automatic logic [CostW-1:0] rand_cost();
		if ($urandom_range(3) == 0)
			return $urandom_range(1) ? '1 : '0;
		return CostW'($urandom());
	endfunction

	// Issue one command transaction, after an optional idle gap, and hold it
	// until the block takes it. The mirror is advanced at the accepting edge.
	task automatic issue(kind_t k, logic [CostW-1:0] c, logic [IdW-1:0] who, int idle_pct);
		int gap;
		gap = 0;
		while (gap < MaxGap && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start     <= 1'b1;
		kind      <= k;
		task_cost <= c;
		requester <= who;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.log_command(k, c, who);
	endtask

	// Write the steal threshold once the block has drained.
	task automatic write_threshold(logic [CntW-1:0] v);
		start <= 1'b0;
		while (sb.answers_due.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.threshold = v;
	endtask

	// Random mix of commands; weights in percent, clear takes the remainder.
	// Every fourth stretch of 16 commands runs without idling.
	task automatic run_mix(int n, int w_take, int w_steal, int w_push, int idle_pct);
		int r;
		kind_t k;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < w_take)
				k = KIND_TAKE;
			else if (r < w_take + w_steal)
				k = KIND_STEAL;
			else if (r < w_take + w_steal + w_push)
				k = KIND_PUSH;
			else
				k = KIND_CLEAR;
			issue(k, rand_cost(), IdW'($urandom_range(255)),
				((i / 16) % 4 == 3) ? 0 : idle_pct);
		end
	endtask

	initial begin
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty deque, cost extremes, refused and granted steals,
		// clear on a non-empty and on an empty deque, fields that must read zero.
		issue(KIND_TAKE,  '0,         '0,    0);  // take from empty
		issue(KIND_STEAL, '0,         '1,    0);  // steal from empty, id echoed
		issue(KIND_PUSH,  '0,         '0,    0);
		issue(KIND_PUSH,  '1,         '0,    0);
		issue(KIND_PUSH,  24'hA5A5A5, '0,    0);
		issue(KIND_TAKE,  '0,         '0,    0);
		issue(KIND_STEAL, '0,         '0,    0);  // below the reset threshold
		issue(KIND_CLEAR, '0,         '0,    0);
		issue(KIND_TAKE,  '0,         '0,    0);  // empty again after clear
		issue(KIND_PUSH,  24'h5A5A5A, '0,    0);
		issue(KIND_TAKE,  '0,         '0,    0);
		write_threshold('0);
		issue(KIND_STEAL, '0,         8'hA5, 0);  // count equals threshold
		issue(KIND_PUSH,  24'h123456, '0,    0);
		issue(KIND_STEAL, '0,         8'h5A, 0);  // granted just above
		issue(KIND_PUSH,  '1,         '0,    0);
		issue(KIND_PUSH,  '0,         '0,    0);
		issue(KIND_STEAL, '1,         8'hFF, 0);
		issue(KIND_TAKE,  '1,         '1,    0);  // requester ignored
		issue(KIND_CLEAR, '1,         '1,    0);
		issue(KIND_PUSH,  24'hFEDCBA, '1,    0);
		issue(KIND_TAKE,  '0,         '1,    0);

		// Random phases at several thresholds and idle ratios.
		write_threshold(CntW'(1023));
		run_mix(40, 30, 25, 40, 0);
		write_threshold(CntW'($urandom_range(20)));
		run_mix(40, 25, 30, 40, 78);

		// Fill to the depth with steals refused at the top threshold, then
		// keep pushing against the full deque.
		write_threshold(CntW'(QueueDepth));
		while (sb.held < QueueDepth)
			issue(($urandom_range(99) < 97) ? KIND_PUSH : KIND_STEAL, rand_cost(),
				IdW'($urandom_range(255)), 35);
		run_mix(15, 0, 40, 60, 35);

		// Hover around full with steals now granted, then a take-heavy stretch.
		write_threshold(CntW'(QueueDepth - 1));
		run_mix(20, 20, 30, 49, 35);
		write_threshold(CntW'($urandom_range(QueueDepth)));
		run_mix(20, 60, 20, 18, 0);
		write_threshold(ThresholdReset);
		run_mix(20, 30, 25, 40, 78);

		start <= 1'b0;
		while (sb.answers_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (sb.answers_due.size() != 0) begin
			$display("%0t: results missing: expected %0d more, actual 0",
				$time, sb.answers_due.size());
			sb.mismatches += sb.answers_due.size();
		end

		$display("Covered %0d pushes (%0d dropped at full), %0d takes (%0d on empty),",
			sb.n_pushed, sb.n_dropped, sb.n_taken, sb.n_empty);
		$display("%0d steals granted, %0d refused, %0d clears, idle ratios 0/35/78 percent",
			sb.n_stolen, sb.n_refused, sb.n_cleared);
		if (sb.mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### work_stealing_task_deque_unit.f
design/wstd_pkg.sv
design/work_stealing_task_deque_unit.sv
tb/sv/tb.sv
